>>> hw/rtl/gdo_pkg.sv
// shared widths, constants, request types and lookup tables for the date offset pipeline
package gdo_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 12;
    localparam int OFF_W   = 17;
    localparam int JDN_W   = 22;
    localparam int WDAY_W  = 3;
    localparam int Q_W     = 7;
    localparam int R_W     = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // day number of the calendar origin used by the forward formula
    localparam logic [JDN_W-1:0] JDN_BASE  = 22'd1721014;
    localparam logic [20:0]      YEAR_MUL  = 21'd367;
    // inverse conversion constants
    localparam logic [JDN_W-1:0] FVF_BIAS  = 22'd68569;
    localparam logic [24:0]      CYC400    = 25'd146097;
    localparam logic [28:0]      Q_RECIP   = 29'd114;
    localparam int               Q_SHIFT   = 22;
    localparam logic [27:0]      YR4K      = 28'd1461001;
    localparam logic [27:0]      YR_SCALE  = 28'd4000;
    localparam logic [23:0]      S_RECIP   = 24'd179;
    localparam int               S_SHIFT   = 16;
    localparam logic [17:0]      QUAD      = 18'd1461;
    localparam logic [17:0]      T_BIAS    = 18'd31;
    localparam logic [15:0]      MON_NUM   = 16'd2447;
    localparam logic [14:0]      MON_SCALE = 15'd80;
    localparam int               U_SHIFT   = 5;
    localparam logic [13:0]      CENT      = 14'd100;
    localparam logic [13:0]      CENT_BASE = 14'd4900;
    localparam logic [3:0]       MARCH_IDX = 4'd11;
    localparam logic [3:0]       YEAR_MON  = 4'd12;

    typedef struct packed {
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic [YEAR_W-1:0]       year;
        logic signed [OFF_W-1:0] offset;
    } t_date_req;

    typedef struct packed {
        logic [JDN_W-1:0]        jdn;
        logic signed [OFF_W-1:0] offset;
    } t_jdn_req;

    typedef struct packed {
        logic [JDN_W-1:0]  jdn;
        logic [WDAY_W-1:0] wday;
        logic [Q_W-1:0]    q;
        logic [R_W-1:0]    r;
    } t_split_req;

    typedef struct packed {
        logic [JDN_W-1:0]   jdn;
        logic [WDAY_W-1:0]  wday;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
    } t_date_res;

    // floor(275 * m / 9)
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd213;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd366;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd427;
            default: v = 9'd458;
        endcase
        return v;
    endfunction

    // floor(2447 * u / 80)
    function automatic logic [8:0] month_start(input logic [3:0] u);
        logic [8:0] v;
        case (u)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd458;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/gdo_to_jdn.sv
// two-stage forward conversion from calendar date to day number
module gdo_to_jdn (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  gdo_pkg::t_date_req i_req,
    output logic              o_vld,
    input  logic              i_rdy,
    output gdo_pkg::t_jdn_req o_req
);
    import gdo_pkg::*;

    localparam int NST = 2;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_adv;

    logic [20:0]        r_a_y367;
    logic [12:0]        r_a_ya;
    logic [8:0]         r_a_c;
    logic [DAY_W-1:0]   r_a_d;
    logic [OFF_W-1:0]   r_a_off;
    logic [1:0]         n_a_a;

    logic [JDN_W-1:0]   r_b_jdn;
    logic [OFF_W-1:0]   r_b_off;
    logic [JDN_W-1:0]   n_b_jdn;
    logic [15:0]        n_b_lp;

    // stage advances when empty or when the next one advances
    always_comb begin
        w_adv[NST] = i_rdy;
        for (int k = NST - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_rdy = w_adv[0];
    assign o_vld = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    // (m + 9) / 12
    always_comb begin
        if (i_req.month < 4'd3) begin
            n_a_a = 2'd0;
        end else if (i_req.month == 4'd15) begin
            n_a_a = 2'd2;
        end else begin
            n_a_a = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_y367 <= 21'(i_req.year) * YEAR_MUL;
            r_a_ya   <= 13'(i_req.year) + 13'(n_a_a);
            r_a_c    <= cum_days(i_req.month);
            r_a_d    <= i_req.day;
            r_a_off  <= i_req.offset;
        end
    end

    always_comb begin
        n_b_lp  = (16'(r_a_ya) * 16'd7) >> 2;
        n_b_jdn = 22'(r_a_y367) - 22'(n_b_lp) + 22'(r_a_c) + 22'(r_a_d) + JDN_BASE;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_b_jdn <= n_b_jdn;
            r_b_off <= r_a_off;
        end
    end

    assign o_req.jdn    = r_b_jdn;
    assign o_req.offset = r_b_off;

endmodule

>>> hw/rtl/gdo_split.sv
// five-stage split of the shifted day number into 400-year cycles and remainder, plus weekday
module gdo_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  gdo_pkg::t_jdn_req   i_req,
    output logic                o_vld,
    input  logic                i_rdy,
    output gdo_pkg::t_split_req o_req
);
    import gdo_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_adv;

    logic [JDN_W-1:0]  r1_p, r1_jdn;
    logic [5:0]        r1_wsum;
    logic [JDN_W-1:0]  n1_p;
    logic [5:0]        n1_wsum;

    logic [JDN_W-1:0]  r2_p, r2_jdn;
    logic [Q_W-1:0]    r2_q0;
    logic [3:0]        r2_wfold;
    logic [28:0]       n2_prod;

    logic [JDN_W-1:0]  r3_p, r3_jdn;
    logic [Q_W-1:0]    r3_q0;
    logic [24:0]       r3_qprod;
    logic [WDAY_W-1:0] r3_wday;
    logic [WDAY_W-1:0] n3_wday;

    logic [JDN_W-1:0]  r4_p, r4_jdn;
    logic [Q_W-1:0]    r4_q;
    logic [24:0]       r4_qmul;
    logic [WDAY_W-1:0] r4_wday;
    logic              n4_hit;

    logic [JDN_W-1:0]  r5_jdn;
    logic [Q_W-1:0]    r5_q;
    logic [R_W-1:0]    r5_r;
    logic [WDAY_W-1:0] r5_wday;
    logic [24:0]       n5_r;

    always_comb begin
        w_adv[NST] = i_rdy;
        for (int k = NST - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_rdy = w_adv[0];
    assign o_vld = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: shift the day number; octal digit sum for mod 7
    always_comb begin
        n1_p    = i_req.jdn + {{(JDN_W-OFF_W){i_req.offset[OFF_W-1]}}, i_req.offset}
                  + FVF_BIAS;
        n1_wsum = 6'(i_req.jdn[JDN_W-1]);
        for (int k = 0; k < 7; k++) begin
            n1_wsum = n1_wsum + 6'(i_req.jdn[3*k +: 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_p    <= n1_p;
            r1_jdn  <= i_req.jdn;
            r1_wsum <= n1_wsum;
        end
    end

    // stage 2: reciprocal estimate of 4p / 146097, low by at most one
    assign n2_prod = 29'(r1_p) * Q_RECIP;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_q0    <= Q_W'(n2_prod >> Q_SHIFT);
            r2_p     <= r1_p;
            r2_jdn   <= r1_jdn;
            r2_wfold <= 4'(r1_wsum[2:0]) + 4'(r1_wsum[5:3]);
        end
    end

    // stage 3: product for the correction check; finish mod 7
    always_comb begin
        if (r2_wfold >= 4'd14) begin
            n3_wday = '0;
        end else if (r2_wfold >= 4'd7) begin
            n3_wday = WDAY_W'(r2_wfold - 4'd7);
        end else begin
            n3_wday = WDAY_W'(r2_wfold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_qprod <= CYC400 * 25'(r2_q0 + 7'd1);
            r3_q0    <= r2_q0;
            r3_p     <= r2_p;
            r3_jdn   <= r2_jdn;
            r3_wday  <= n3_wday;
        end
    end

    // stage 4: correct the quotient and keep 146097 * q
    assign n4_hit = r3_qprod <= {1'b0, r3_p, 2'b00};

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_q    <= r3_q0 + Q_W'(n4_hit);
            r4_qmul <= n4_hit ? r3_qprod : r3_qprod - CYC400;
            r4_p    <= r3_p;
            r4_jdn  <= r3_jdn;
            r4_wday <= r3_wday;
        end
    end

    // stage 5: remainder within the cycle
    assign n5_r = 25'(r4_p) - ((r4_qmul + 25'd3) >> 2);

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_r    <= n5_r[R_W-1:0];
            r5_q    <= r4_q;
            r5_jdn  <= r4_jdn;
            r5_wday <= r4_wday;
        end
    end

    assign o_req.jdn  = r5_jdn;
    assign o_req.wday = r5_wday;
    assign o_req.q    = r5_q;
    assign o_req.r    = r5_r;

endmodule

>>> hw/rtl/gdo_to_date.sv
// seven-stage back conversion from cycle remainder to year, month and day
module gdo_to_date (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  gdo_pkg::t_split_req i_req,
    output logic                o_vld,
    input  logic                i_rdy,
    output gdo_pkg::t_date_res  o_res
);
    import gdo_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_adv;

    logic [JDN_W-1:0]  r1_jdn, r2_jdn, r3_jdn, r4_jdn, r5_jdn, r6_jdn;
    logic [WDAY_W-1:0] r1_wday, r2_wday, r3_wday, r4_wday, r5_wday, r6_wday;
    logic [Q_W-1:0]    r1_q, r2_q, r3_q, r4_q, r5_q, r6_q;

    logic [R_W-1:0]    r1_r, r2_r, r3_r;
    logic [6:0]        r1_s0, r2_s0;
    logic [R_W-1:0]    n1_rp1;
    logic [23:0]       n1_prod;

    logic [27:0]       r2_sprod, r2_rr;

    logic [6:0]        r3_s, r4_s, r5_s, r6_s;

    logic [8:0]        r4_t, r5_t, r6_t;
    logic [17:0]       n4_t;

    logic [3:0]        r5_u0;
    logic [14:0]       r5_t80;

    logic [3:0]        r6_u;
    logic              n6_hit;

    logic [JDN_W-1:0]   r7_jdn;
    logic [WDAY_W-1:0]  r7_wday;
    logic [MONTH_W-1:0] r7_month;
    logic [DAY_W-1:0]   r7_day;
    logic [YEAR_W-1:0]  r7_year;
    logic               n7_v;
    logic [13:0]        n7_year;
    logic [8:0]         n7_day;

    always_comb begin
        w_adv[NST] = i_rdy;
        for (int k = NST - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_rdy = w_adv[0];
    assign o_vld = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: estimate of 4000 (r + 1) / 1461001, low by at most one
    always_comb begin
        n1_rp1  = i_req.r + 16'd1;
        n1_prod = 24'(n1_rp1) * S_RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_s0   <= 7'(n1_prod >> S_SHIFT);
            r1_r    <= i_req.r;
            r1_q    <= i_req.q;
            r1_jdn  <= i_req.jdn;
            r1_wday <= i_req.wday;
        end
    end

    // stage 2: both sides of the correction check
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_sprod <= YR4K * 28'(r1_s0 + 7'd1);
            r2_rr    <= (28'(r1_r) + 28'd1) * YR_SCALE;
            r2_s0    <= r1_s0;
            r2_r     <= r1_r;
            r2_q     <= r1_q;
            r2_jdn   <= r1_jdn;
            r2_wday  <= r1_wday;
        end
    end

    // stage 3: corrected year within the century
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_s    <= r2_s0 + 7'(r2_sprod <= r2_rr);
            r3_r    <= r2_r;
            r3_q    <= r2_q;
            r3_jdn  <= r2_jdn;
            r3_wday <= r2_wday;
        end
    end

    // stage 4: day within the year counted from march
    assign n4_t = 18'(r3_r) - ((18'(r3_s) * QUAD) >> 2) + T_BIAS;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_t    <= n4_t[8:0];
            r4_s    <= r3_s;
            r4_q    <= r3_q;
            r4_jdn  <= r3_jdn;
            r4_wday <= r3_wday;
        end
    end

    // stage 5: t / 32 underestimates 80 t / 2447 by less than one
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_u0   <= 4'(r4_t >> U_SHIFT);
            r5_t80  <= 15'(r4_t) * MON_SCALE;
            r5_t    <= r4_t;
            r5_s    <= r4_s;
            r5_q    <= r4_q;
            r5_jdn  <= r4_jdn;
            r5_wday <= r4_wday;
        end
    end

    // stage 6: corrected month index
    assign n6_hit = (MON_NUM * 16'(r5_u0 + 4'd1)) <= 16'(r5_t80);

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_u    <= r5_u0 + 4'(n6_hit);
            r6_t    <= r5_t;
            r6_s    <= r5_s;
            r6_q    <= r5_q;
            r6_jdn  <= r5_jdn;
            r6_wday <= r5_wday;
        end
    end

    // stage 7: assemble the date, year wraps to the field
    always_comb begin
        n7_v    = r6_u >= MARCH_IDX;
        n7_year = 14'(r6_q) * CENT - CENT_BASE + 14'(r6_s) + 14'(n7_v);
        n7_day  = r6_t - month_start(r6_u);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r7_year  <= n7_year[YEAR_W-1:0];
            r7_month <= r6_u + 4'd2 - (n7_v ? YEAR_MON : 4'd0);
            r7_day   <= n7_day[DAY_W-1:0];
            r7_jdn   <= r6_jdn;
            r7_wday  <= r6_wday;
        end
    end

    assign o_res.jdn   = r7_jdn;
    assign o_res.wday  = r7_wday;
    assign o_res.month = r7_month;
    assign o_res.day   = r7_day;
    assign o_res.year  = r7_year;

endmodule

>>> hw/rtl/gregorian_date_offset.sv
// top level: gregorian date plus day offset, fully pipelined
//
//  channel  | dir | tdata fields (lsb first)
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | month[3:0] day[8:4] year[20:9] offset_days[37:21] pad[39:38]
//  m_axis   | out | day_number[21:0] month[25:22] day[30:26] year[42:31]
//           |     | weekday[45:43] pad[47:46]
//
// - fourteen register stages: two for date to day number, five for the
//   400-year split and weekday, seven for the year/month/day rebuild
// - one request enters per cycle unless an output stall has filled the pipe
// - every stage holds its own valid bit and advances when empty or when the
//   stage after it advances, so bubbles close up under a stalled output
// - the last stage is the output register; a stall holds it and everything
//   behind it that is full, nothing is dropped or repeated
// - synchronous active-low reset clears the valid bits only
module gregorian_date_offset (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // month[3:0], day[8:4], year[20:9], offset_days[37:21], zero pad [39:38]
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // day_number[21:0], month[25:22], day[30:26], year[42:31], weekday[45:43],
    // zero pad [47:46]
    output logic [47:0] o_m_axis_tdata
);
    import gdo_pkg::*;

    t_date_req  w_in_req;
    t_jdn_req   w_jdn_req;
    t_split_req w_split_req;
    t_date_res  w_res;

    logic w_jdn_vld, w_jdn_rdy;
    logic w_split_vld, w_split_rdy;

    // unpack the incoming request
    assign w_in_req.month  = i_s_axis_tdata[3:0];
    assign w_in_req.day    = i_s_axis_tdata[8:4];
    assign w_in_req.year   = i_s_axis_tdata[20:9];
    assign w_in_req.offset = i_s_axis_tdata[37:21];

    // date to day number
    gdo_to_jdn u_to_jdn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_axis_tvalid),
        .o_rdy   (o_s_axis_tready),
        .i_req   (w_in_req),
        .o_vld   (w_jdn_vld),
        .i_rdy   (w_jdn_rdy),
        .o_req   (w_jdn_req)
    );

    // shifted day number into 400-year cycles and remainder, weekday of input
    gdo_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_jdn_vld),
        .o_rdy   (w_jdn_rdy),
        .i_req   (w_jdn_req),
        .o_vld   (w_split_vld),
        .i_rdy   (w_split_rdy),
        .o_req   (w_split_req)
    );

    // remainder back to year, month and day
    gdo_to_date u_to_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_split_vld),
        .o_rdy   (w_split_rdy),
        .i_req   (w_split_req),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_res   (w_res)
    );

    // pack the result, pad bits tied low
    assign o_m_axis_tdata = {2'b00, w_res.wday, w_res.year, w_res.day, w_res.month, w_res.jdn};

endmodule

>>> tb/gregorian_date_offset_tb.sv
// self-checking testbench for the gregorian date offset pipeline
`timescale 1ns / 1ps

module gregorian_date_offset_tb;

    import gdo_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int DRAIN_CYCLES = 40;      // pipe is 14 deep, leave room for stray results
    localparam int CYCLE_LIMIT  = 200000;  // well above the slowest legal run

    // one request as handed to the block, plus an optional hand-typed answer
    typedef struct packed {
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic [YEAR_W-1:0]       year;
        logic signed [OFF_W-1:0] offset;
        bit                      typed;
        t_date_res               want;
    } t_date_case;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // month, day, year, offset_days, zero pad
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // day_number, month, day, year, weekday, zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_date_case directed_cases[$];
    t_date_res  pending_dates[$];     // shifted dates still owed by the pipe
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         gap_cycles = 0;

    gregorian_date_offset DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // date -> day number -> shifted date, all in signed 64-bit so that the
    // truncating divisions behave like plain integer math
    function automatic t_date_res predict_shift(input t_date_case c);
        longint m, d, y, off, jdn, p, q, r, s, t, u, v, ny, nm, nd;
        t_date_res res;
        m   = c.month;
        d   = c.day;
        y   = c.year;
        off = c.offset;
        jdn = 367 * y - (7 * (y + (m + 9) / 12)) / 4 + (275 * m) / 9 + d + 1721014;
        // fliegel-van flandern inverse on the shifted day number
        p  = jdn + off + 68569;
        q  = (4 * p) / 146097;
        r  = p - (146097 * q + 3) / 4;
        s  = (4000 * (r + 1)) / 1461001;
        t  = r - (1461 * s) / 4 + 31;
        u  = (80 * t) / 2447;
        v  = u / 11;
        ny = 100 * (q - 49) + s + v;
        nm = u + 2 - 12 * v;
        nd = t - (2447 * u) / 80;
        res.jdn   = jdn[JDN_W-1:0];
        res.wday  = 3'(jdn % 7);
        res.month = nm[MONTH_W-1:0];
        res.day   = nd[DAY_W-1:0];
        res.year  = ny[YEAR_W-1:0];   // wraps as two's complement outside the field
        return res;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(input t_date_case c);
        return {2'b00, c.offset, c.year, c.day, c.month};
    endfunction

    // typed rows keep the input date (offset zero), so only day number and
    // weekday need writing down
    function automatic void add_case(input int m, input int d, input int y, input int off,
                                     input bit typed = 1'b0, input int jdn = 0,
                                     input int wd = 0);
        t_date_case c;
        c.month      = m[MONTH_W-1:0];
        c.day        = d[DAY_W-1:0];
        c.year       = y[YEAR_W-1:0];
        c.offset     = off[OFF_W-1:0];
        c.typed      = typed;
        c.want.jdn   = jdn[JDN_W-1:0];
        c.want.wday  = wd[WDAY_W-1:0];
        c.want.month = c.month;
        c.want.day   = c.day;
        c.want.year  = c.year;
        directed_cases.push_back(c);
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // sender: bursts of random length separated by random gaps, with a fair
    // share of back-to-back bursts
    task automatic send_case(input t_date_case c);
        if (burst_left == 0) begin
            gap_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 40);
            if (gap_cycles != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap_cycles) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tdata  <= pack_request(c);
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // request taken at this edge
        pending_dates.push_back(c.typed ? c.want : predict_shift(c));
    endtask

    initial begin : source
        t_date_case c;
        logic [63:0] raw;
        int off_i;

        // known day numbers and weekdays at the window edges and the epoch
        add_case(1, 1, 2000, 0, 1'b1, 2451545, 5);
        add_case(1, 1, 1901, 0, 1'b1, 2415386, 1);
        add_case(12, 31, 2099, 0, 1'b1, 2488069, 3);
        // year and month rollovers, leap days
        add_case(1, 1, 1901, -1);
        add_case(12, 31, 2099, 1);
        add_case(2, 28, 1904, 1);
        add_case(2, 28, 2000, 1);
        add_case(2, 29, 2024, 366);
        add_case(12, 31, 2023, -365);
        // offset extremes
        add_case(1, 1, 2000, 65535);
        add_case(1, 1, 2000, -65536);
        add_case(1, 1, 1901, -65536);
        add_case(12, 31, 2099, 65535);
        // out-of-range date fields go through the same formulas unchecked
        add_case(0, 0, 0, -65536);
        add_case(15, 31, 4095, 65535);
        add_case(13, 31, 2099, 0);
        add_case(0, 15, 2000, 0);
        add_case(1, 1, 0, 0);
        add_case(12, 31, 4095, -1);
        add_case(3, 0, 2000, 0);
        add_case(2, 31, 1999, 0);
        add_case(14, 30, 1, 12345);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_cases[k]) send_case(directed_cases[k]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            c = '0;
            if ($urandom_range(0, 9) < 7) begin
                // calendar dates inside the window, small or full-range offsets
                c.month = 4'($urandom_range(1, 12));
                c.day   = 5'($urandom_range(1, (c.month == 2) ? 29 : 31));
                c.year  = 12'($urandom_range(1901, 2099));
                if ($urandom_range(0, 1) == 0) begin
                    off_i = int'($urandom_range(0, 2000)) - 1000;
                    c.offset = off_i[OFF_W-1:0];
                end else begin
                    c.offset = 17'($urandom_range(0, 131071));
                end
            end else begin
                // raw bit patterns on every field
                raw = {$urandom, $urandom};
                c.month  = raw[3:0];
                c.day    = raw[8:4];
                c.year   = raw[20:9];
                c.offset = raw[37:21];
            end
            send_case(c);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS gregorian_date_offset");
        end else begin
            $display("FAIL gregorian_date_offset");
        end
        $finish;
    end

    // receiver: phases of always-ready, random, fixed-mask and heavy stalling
    always @(posedge i_clk) begin : sink
        int phase_left;
        int sink_mode;
        logic [7:0] stall_mask;
        if (phase_left == 0) begin
            phase_left = $urandom_range(20, 150);
            sink_mode  = $urandom_range(0, 3);
            stall_mask = 8'($urandom);
        end
        phase_left--;
        case (sink_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                i_m_axis_tready <= stall_mask[cycle_count % 8];
            end
            default: begin
                i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // compare every delivered result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_date_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: result with none expected, tdata %h", $time, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                check_field("day_number", want.jdn,   o_m_axis_tdata[21:0]);
                check_field("month",      want.month, o_m_axis_tdata[25:22]);
                check_field("day",        want.day,   o_m_axis_tdata[30:26]);
                check_field("year",       want.year,  o_m_axis_tdata[42:31]);
                check_field("weekday",    want.wday,  o_m_axis_tdata[45:43]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_dates.size());
            $display("FAIL gregorian_date_offset");
            $finish;
        end
    end

endmodule
